@@ rtl/core/assert_macros.svh @@
// Concurrent assertion helpers shared by the core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define TSQ_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tsq assertion failed");

// Checked on every clock edge, reset included.
`define TSQ_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("tsq assertion failed");

`endif

@@ rtl/core/tsq_pkg.sv @@
package tsq_pkg;

    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;
    localparam int WIN_BITS      = 12;
    localparam int CNT_BITS      = 8;
    localparam int COEF_BITS     = 16;
    localparam int POINT_BITS    = 16;
    localparam int STATUS_BITS   = 2;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_VALID_MIN    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_VALID_MAX    = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_AGREE_WINDOW = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_MAX_ATTEMPTS = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_X_GAIN       = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_X_OFFSET     = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_Y_GAIN       = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_Y_OFFSET     = 3'd7;

    // reset values
    localparam logic [WIN_BITS-1:0] RST_VALID_MIN    = 12'd100;
    localparam logic [WIN_BITS-1:0] RST_VALID_MAX    = 12'd4000;
    localparam logic [WIN_BITS-1:0] RST_AGREE_WINDOW = 12'd50;
    localparam logic [CNT_BITS-1:0] RST_MAX_ATTEMPTS = 8'd10;

    // result status codes
    localparam logic [STATUS_BITS-1:0] ST_POINT    = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_FAIL     = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_NO_TOUCH = 2'd2;

    typedef struct packed {
        logic [WIN_BITS-1:0]  valid_min;
        logic [WIN_BITS-1:0]  valid_max;
        logic [WIN_BITS-1:0]  agree_window;
        logic [CNT_BITS-1:0]  max_attempts;
        logic [COEF_BITS-1:0] x_gain;
        logic [COEF_BITS-1:0] x_offset;
        logic [COEF_BITS-1:0] y_gain;
        logic [COEF_BITS-1:0] y_offset;
    } t_cfg;

    typedef struct packed {
        logic                   emit;
        logic [STATUS_BITS-1:0] status;
    } t_dec;

endpackage

@@ rtl/core/tsq_in_if.sv @@
interface tsq_in_if #(
    parameter int SAMPLE_BITS = 12
);
    logic                   valid;
    logic                   ready;
    logic                   pen_down;
    logic [SAMPLE_BITS-1:0] raw_x;
    logic [SAMPLE_BITS-1:0] raw_y;

    modport source (output valid, output pen_down, output raw_x, output raw_y, input ready);
    modport sink   (input valid, input pen_down, input raw_x, input raw_y, output ready);
endinterface

@@ rtl/core/tsq_out_if.sv @@
interface tsq_out_if;
    logic                                valid;
    logic                                ready;
    logic [tsq_pkg::STATUS_BITS-1:0]     status;
    logic [tsq_pkg::POINT_BITS-1:0]      point_x;
    logic [tsq_pkg::POINT_BITS-1:0]      point_y;

    modport source (output valid, output status, output point_x, output point_y, input ready);
    modport sink   (input valid, input status, input point_x, input point_y, output ready);
endinterface

@@ rtl/core/touch_sample_qualify_and_scale_unit.sv @@
// An item passes through the input register and then the result register, with the qualify
// and scale logic as a single pass between them. Throughput: one item per cycle while the
// result slot is free; an item that yields no result still needs a free slot to advance.
// Reset (i_rst_n low, synchronous): configuration returns to its defaults, the held sample,
// pen attempt and failure count clear, and both pipeline stages empty.
`include "assert_macros.svh"

module touch_sample_qualify_and_scale_unit #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    tsq_in_if.sink                              i_smp,
    tsq_out_if.source                           o_pt,
    input  logic                                i_cfg_we,
    input  logic [tsq_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [tsq_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);

    tsq_pkg::t_cfg                      w_cfg;
    tsq_pkg::t_dec                      w_dec;
    logic [SAMPLE_BITS-1:0]             w_avg_x, w_avg_y;
    logic [tsq_pkg::POINT_BITS-1:0]     w_px, w_py;

    // input register
    logic                               r_in_vld;
    logic                               r_pen;
    logic [SAMPLE_BITS-1:0]             r_raw_x, r_raw_y;

    // result register
    logic                               r_out_vld;
    logic [tsq_pkg::STATUS_BITS-1:0]    r_status;
    logic [tsq_pkg::POINT_BITS-1:0]     r_px, r_py;

    logic                               w_out_free;
    logic                               w_advance;
    logic                               w_in_rdy;

    // waiting result classes, for the checks below
    logic                               w_out_no_point;
    logic                               w_out_no_touch;

    // The result slot is free when empty or being drained this cycle.
    assign w_out_free = !r_out_vld || o_pt.ready;
    // Advance the held item through qualify/scale whenever the result slot can take it.
    assign w_advance  = r_in_vld && w_out_free;
    // Take a new item when the input register is empty or moving on; refuse items in reset.
    assign w_in_rdy   = i_rst_n && (!r_in_vld || w_advance);

    tsq_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    tsq_qualify #(.SAMPLE_BITS(SAMPLE_BITS)) u_qual (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_advance  (w_advance),
        .i_pen_down (r_pen),
        .i_raw_x    (r_raw_x),
        .i_raw_y    (r_raw_y),
        .o_dec      (w_dec),
        .o_avg_x    (w_avg_x),
        .o_avg_y    (w_avg_y)
    );

    tsq_scale #(.SAMPLE_BITS(SAMPLE_BITS)) u_scale_x (
        .i_avg    (w_avg_x),
        .i_gain   (w_cfg.x_gain),
        .i_offset (w_cfg.x_offset),
        .o_point  (w_px)
    );

    tsq_scale #(.SAMPLE_BITS(SAMPLE_BITS)) u_scale_y (
        .i_avg    (w_avg_y),
        .i_gain   (w_cfg.y_gain),
        .i_offset (w_cfg.y_offset),
        .o_point  (w_py)
    );

    // Input stage: hold the item until it advances.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_in_rdy) begin
            r_in_vld <= i_smp.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_rdy && i_smp.valid) begin
            r_pen   <= i_smp.pen_down;
            r_raw_x <= i_smp.raw_x;
            r_raw_y <= i_smp.raw_y;
        end
    end

    // Result stage: load on an emitting advance, drop once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_free) begin
            r_out_vld <= w_advance && w_dec.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_dec.emit) begin
            r_status <= w_dec.status;
            // the point is zero for failure and no-touch results
            if (w_dec.status == tsq_pkg::ST_POINT) begin
                r_px <= w_px;
                r_py <= w_py;
            end else begin
                r_px <= '0;
                r_py <= '0;
            end
        end
    end

    assign i_smp.ready   = w_in_rdy;
    assign o_pt.valid    = r_out_vld;
    assign o_pt.status   = r_status;
    assign o_pt.point_x  = r_px;
    assign o_pt.point_y  = r_py;

    assign w_out_no_point = r_out_vld && (r_status != tsq_pkg::ST_POINT);
    assign w_out_no_touch = r_out_vld && (r_status == tsq_pkg::ST_NO_TOUCH);

    // A failure or no-touch result never carries a point.
    `TSQ_ASSERT(a_zero_point, i_clk, i_rst_n, w_out_no_point |-> (r_px == '0 && r_py == '0))

    // An item blocked by a full result slot stays in the input register.
    `TSQ_ASSERT(a_in_hold, i_clk, i_rst_n, (r_in_vld && !w_advance) |=> r_in_vld)

    // A pen-up item always produces a no-touch result.
    `TSQ_ASSERT(a_pen_up, i_clk, i_rst_n, (w_advance && !r_pen) |=> w_out_no_touch)

    // Both stages are empty after every reset cycle.
    `TSQ_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> (!r_in_vld && !r_out_vld))

endmodule

@@ rtl/core/tsq_cfg_regs.sv @@
module tsq_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [tsq_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [tsq_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    output tsq_pkg::t_cfg                       o_cfg
);

    tsq_pkg::t_cfg r_cfg;
    tsq_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tsq_pkg::REG_VALID_MIN:
                    n_cfg.valid_min = i_cfg_data[tsq_pkg::WIN_BITS-1:0];
                tsq_pkg::REG_VALID_MAX:
                    n_cfg.valid_max = i_cfg_data[tsq_pkg::WIN_BITS-1:0];
                tsq_pkg::REG_AGREE_WINDOW:
                    n_cfg.agree_window = i_cfg_data[tsq_pkg::WIN_BITS-1:0];
                tsq_pkg::REG_MAX_ATTEMPTS:
                    n_cfg.max_attempts = i_cfg_data[tsq_pkg::CNT_BITS-1:0];
                tsq_pkg::REG_X_GAIN:   n_cfg.x_gain   = i_cfg_data;
                tsq_pkg::REG_X_OFFSET: n_cfg.x_offset = i_cfg_data;
                tsq_pkg::REG_Y_GAIN:   n_cfg.y_gain   = i_cfg_data;
                tsq_pkg::REG_Y_OFFSET: n_cfg.y_offset = i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.valid_min    <= tsq_pkg::RST_VALID_MIN;
            r_cfg.valid_max    <= tsq_pkg::RST_VALID_MAX;
            r_cfg.agree_window <= tsq_pkg::RST_AGREE_WINDOW;
            r_cfg.max_attempts <= tsq_pkg::RST_MAX_ATTEMPTS;
            r_cfg.x_gain       <= '0;
            r_cfg.x_offset     <= '0;
            r_cfg.y_gain       <= '0;
            r_cfg.y_offset     <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ rtl/core/tsq_qualify.sv @@
module tsq_qualify #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  tsq_pkg::t_cfg           i_cfg,
    input  logic                    i_advance,
    input  logic                    i_pen_down,
    input  logic [SAMPLE_BITS-1:0]  i_raw_x,
    input  logic [SAMPLE_BITS-1:0]  i_raw_y,
    output tsq_pkg::t_dec           o_dec,
    output logic [SAMPLE_BITS-1:0]  o_avg_x,
    output logic [SAMPLE_BITS-1:0]  o_avg_y
);

    localparam int CMP_BITS = (SAMPLE_BITS > tsq_pkg::WIN_BITS) ? SAMPLE_BITS
                                                                : tsq_pkg::WIN_BITS;

    logic [SAMPLE_BITS-1:0]        r_held_x, n_held_x;
    logic [SAMPLE_BITS-1:0]        r_held_y, n_held_y;
    logic                          r_have_first, n_have_first;
    logic [tsq_pkg::CNT_BITS-1:0]  r_failed, n_failed;

    logic [CMP_BITS-1:0]           w_min, w_max, w_win, w_x, w_y, w_dx, w_dy;
    logic [SAMPLE_BITS-1:0]        w_abs_x, w_abs_y;
    logic [SAMPLE_BITS:0]          w_sum_x, w_sum_y;
    logic                          w_valid, w_agree;
    logic [tsq_pkg::CNT_BITS-1:0]  w_limit, w_fail_cnt;
    tsq_pkg::t_dec                 w_dec;

    assign w_min = CMP_BITS'(i_cfg.valid_min);
    assign w_max = CMP_BITS'(i_cfg.valid_max);
    assign w_win = CMP_BITS'(i_cfg.agree_window);
    assign w_x   = CMP_BITS'(i_raw_x);
    assign w_y   = CMP_BITS'(i_raw_y);

    assign w_valid = (w_x >= w_min) && (w_x <= w_max) && (w_y >= w_min) && (w_y <= w_max);

    assign w_abs_x = (r_held_x > i_raw_x) ? (r_held_x - i_raw_x) : (i_raw_x - r_held_x);
    assign w_abs_y = (r_held_y > i_raw_y) ? (r_held_y - i_raw_y) : (i_raw_y - r_held_y);
    assign w_dx    = CMP_BITS'(w_abs_x);
    assign w_dy    = CMP_BITS'(w_abs_y);
    assign w_agree = (w_dx < w_win) && (w_dy < w_win);

    // floor average of held and new sample
    assign w_sum_x = {1'b0, r_held_x} + {1'b0, i_raw_x};
    assign w_sum_y = {1'b0, r_held_y} + {1'b0, i_raw_y};
    assign o_avg_x = w_sum_x[SAMPLE_BITS:1];
    assign o_avg_y = w_sum_y[SAMPLE_BITS:1];

    // a zero limit acts as one
    assign w_limit    = (i_cfg.max_attempts == '0) ? tsq_pkg::CNT_BITS'(1) : i_cfg.max_attempts;
    assign w_fail_cnt = r_failed + tsq_pkg::CNT_BITS'(1);

    always_comb begin
        n_held_x     = r_held_x;
        n_held_y     = r_held_y;
        n_have_first = r_have_first;
        n_failed     = r_failed;
        w_dec.emit   = 1'b0;
        w_dec.status = tsq_pkg::ST_POINT;
        if (!i_pen_down) begin
            n_have_first = 1'b0;
            n_failed     = '0;
            w_dec.emit   = 1'b1;
            w_dec.status = tsq_pkg::ST_NO_TOUCH;
        end else if (w_valid && !r_have_first) begin
            n_held_x     = i_raw_x;
            n_held_y     = i_raw_y;
            n_have_first = 1'b1;
        end else if (w_valid && w_agree) begin
            n_have_first = 1'b0;
            n_failed     = '0;
            w_dec.emit   = 1'b1;
            w_dec.status = tsq_pkg::ST_POINT;
        end else begin
            n_have_first = 1'b0;
            if (w_fail_cnt >= w_limit) begin
                n_failed     = '0;
                w_dec.emit   = 1'b1;
                w_dec.status = tsq_pkg::ST_FAIL;
            end else begin
                n_failed = w_fail_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_x     <= '0;
            r_held_y     <= '0;
            r_have_first <= 1'b0;
            r_failed     <= '0;
        end else if (i_advance) begin
            r_held_x     <= n_held_x;
            r_held_y     <= n_held_y;
            r_have_first <= n_have_first;
            r_failed     <= n_failed;
        end
    end

    assign o_dec = w_dec;

endmodule

@@ rtl/core/tsq_scale.sv @@
module tsq_scale #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic [SAMPLE_BITS-1:0]              i_avg,
    input  logic [tsq_pkg::COEF_BITS-1:0]       i_gain,
    input  logic [tsq_pkg::COEF_BITS-1:0]       i_offset,
    output logic [tsq_pkg::POINT_BITS-1:0]      o_point
);

    localparam int PROD_BITS = SAMPLE_BITS + 1 + tsq_pkg::COEF_BITS;

    logic signed [PROD_BITS-1:0] w_prod;
    logic signed [31:0]          w_prod32;

    // unsigned average times signed gain; keep bits 16..31 of the 32-bit product
    assign w_prod   = $signed({1'b0, i_avg}) * $signed(i_gain);
    assign w_prod32 = 32'(w_prod);
    assign o_point  = w_prod32[31:16] + i_offset;

endmodule

@@ tb/tb_touch_sample_qualify_and_scale_unit.sv @@
module tb_touch_sample_qualify_and_scale_unit;
    import tsq_pkg::*;

    localparam int SAMPLE_BITS = 12;
    // generous bound on the length of a correct run
    localparam int LIMIT_CYCLES = 200000;

    // Expected-result store and predictor of the qualify and scale behaviour.
    class touch_point_scoreboard;
        typedef struct {
            logic [STATUS_BITS-1:0] status;
            logic [POINT_BITS-1:0]  px;
            logic [POINT_BITS-1:0]  py;
        } t_point;

        t_cfg                   cfg;
        logic [SAMPLE_BITS-1:0] held_x;
        logic [SAMPLE_BITS-1:0] held_y;
        bit                     have_first;
        logic [CNT_BITS-1:0]    fail_cnt;
        t_point                 expected_q[$];
        int                     mismatches;
        int                     n_point;
        int                     n_fail;
        int                     n_none;
        int                     n_samples;

        function new();
            cfg.valid_min    = RST_VALID_MIN;
            cfg.valid_max    = RST_VALID_MAX;
            cfg.agree_window = RST_AGREE_WINDOW;
            cfg.max_attempts = RST_MAX_ATTEMPTS;
            cfg.x_gain       = '0;
            cfg.x_offset     = '0;
            cfg.y_gain       = '0;
            cfg.y_offset     = '0;
            held_x           = '0;
            held_y           = '0;
            have_first       = 1'b0;
            fail_cnt         = '0;
        endfunction

        function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
            case (idx)
                REG_VALID_MIN:    cfg.valid_min    = data[WIN_BITS-1:0];
                REG_VALID_MAX:    cfg.valid_max    = data[WIN_BITS-1:0];
                REG_AGREE_WINDOW: cfg.agree_window = data[WIN_BITS-1:0];
                REG_MAX_ATTEMPTS: cfg.max_attempts = data[CNT_BITS-1:0];
                REG_X_GAIN:       cfg.x_gain       = data;
                REG_X_OFFSET:     cfg.x_offset     = data;
                REG_Y_GAIN:       cfg.y_gain       = data;
                REG_Y_OFFSET:     cfg.y_offset     = data;
                default: ;
            endcase
        endfunction

        function bit in_window(logic [SAMPLE_BITS-1:0] v);
            return (v >= cfg.valid_min) && (v <= cfg.valid_max);
        endfunction

        function bit agrees(logic [SAMPLE_BITS-1:0] a, logic [SAMPLE_BITS-1:0] b);
            logic [SAMPLE_BITS-1:0] d;
            d = (a > b) ? a - b : b - a;
            return d < cfg.agree_window;
        endfunction

        // signed gain, product kept modulo 2^32, upper half plus offset
        function logic [POINT_BITS-1:0] scale_axis(logic [SAMPLE_BITS-1:0] avg,
                                                   logic [COEF_BITS-1:0] gain,
                                                   logic [COEF_BITS-1:0] off);
            logic [31:0] prod;
            prod = {20'd0, avg} * {{16{gain[COEF_BITS-1]}}, gain};
            return prod[31:16] + off;
        endfunction

        function void push(logic [STATUS_BITS-1:0] st, logic [POINT_BITS-1:0] px,
                           logic [POINT_BITS-1:0] py);
            t_point p;
            p.status = st;
            p.px     = px;
            p.py     = py;
            expected_q.push_back(p);
        endfunction

        function void count_failure();
            logic [CNT_BITS-1:0] lim;
            lim        = (cfg.max_attempts == '0) ? CNT_BITS'(1) : cfg.max_attempts;
            have_first = 1'b0;
            fail_cnt   = fail_cnt + 1'b1;
            if (fail_cnt >= lim) begin
                fail_cnt = '0;
                push(ST_FAIL, '0, '0);
            end
        endfunction

        function void note_sample(logic pen, logic [SAMPLE_BITS-1:0] x,
                                  logic [SAMPLE_BITS-1:0] y);
            logic [SAMPLE_BITS:0] sx;
            logic [SAMPLE_BITS:0] sy;
            n_samples++;
            if (!pen) begin
                have_first = 1'b0;
                fail_cnt   = '0;
                push(ST_NO_TOUCH, '0, '0);
            end else if (!in_window(x) || !in_window(y)) begin
                count_failure();
            end else if (!have_first) begin
                held_x     = x;
                held_y     = y;
                have_first = 1'b1;
            end else if (agrees(held_x, x) && agrees(held_y, y)) begin
                sx         = held_x + x;
                sy         = held_y + y;
                have_first = 1'b0;
                fail_cnt   = '0;
                push(ST_POINT, scale_axis(sx[SAMPLE_BITS:1], cfg.x_gain, cfg.x_offset),
                     scale_axis(sy[SAMPLE_BITS:1], cfg.y_gain, cfg.y_offset));
            end else begin
                count_failure();
            end
        endfunction

        function void check_point(logic [STATUS_BITS-1:0] st, logic [POINT_BITS-1:0] px,
                                  logic [POINT_BITS-1:0] py);
            t_point e;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d x %0h y %0h", st, px, py);
                return;
            end
            e = expected_q.pop_front();
            case (e.status)
                ST_POINT: n_point++;
                ST_FAIL:  n_fail++;
                default:  n_none++;
            endcase
            if (st !== e.status || px !== e.px || py !== e.py) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch: expected status %0d x %0h y %0h, got %0d x %0h y %0h",
                             e.status, e.px, e.py, st, px, py);
            end
        endfunction
    endclass

    typedef struct {
        t_cfg cfg;
        int   n_items;
        int   pen_pct;
        bit   steady;
    } t_phase;

    logic i_clk;
    logic i_rst_n;
    logic                     i_cfg_we;
    logic [CFG_IDX_BITS-1:0]  i_cfg_idx;
    logic [CFG_DATA_BITS-1:0] i_cfg_data;

    tsq_in_if #(.SAMPLE_BITS(SAMPLE_BITS)) smp_if ();
    tsq_out_if                             pt_if ();

    touch_point_scoreboard sb = new();

    // when set, neither side inserts idle cycles
    bit steady = 1'b0;
    // current touch position that jittered samples cluster around
    int base_x = 2000;
    int base_y = 2000;

    t_phase plan[8];

    touch_sample_qualify_and_scale_unit #(.SAMPLE_BITS(SAMPLE_BITS)) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_smp      (smp_if),
        .o_pt       (pt_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #(LIMIT_CYCLES * 10);
        $display("CHECK FAILED");
        $finish;
    end

    // Result side: check every accepted item, then decide whether to stall next cycle.
    initial begin
        pt_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pt_if.valid && pt_if.ready)
                sb.check_point(pt_if.status, pt_if.point_x, pt_if.point_y);
            pt_if.ready <= steady || ($urandom_range(0, 99) >= 6);
        end
    end

    // Offer one sample; return once it has been accepted. Valid stays high afterwards
    // so back-to-back items need no gap.
    task automatic send_sample(input logic pen, input logic [SAMPLE_BITS-1:0] x,
                               input logic [SAMPLE_BITS-1:0] y);
        while (!steady && $urandom_range(0, 99) < 6) begin
            smp_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        smp_if.valid    <= 1'b1;
        smp_if.pen_down <= pen;
        smp_if.raw_x    <= x;
        smp_if.raw_y    <= y;
        @(posedge i_clk);
        while (!smp_if.ready) @(posedge i_clk);
        sb.note_sample(pen, x, y);
    endtask

    // Drop valid and wait until the block holds nothing, results and in-flight items alike.
    task automatic settle();
        smp_if.valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic program_reg(input logic [CFG_IDX_BITS-1:0] idx,
                               input logic [CFG_DATA_BITS-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    task automatic end_writes();
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apply_settings(input t_cfg c);
        program_reg(REG_VALID_MIN,    {4'd0, c.valid_min});
        program_reg(REG_VALID_MAX,    {4'd0, c.valid_max});
        program_reg(REG_AGREE_WINDOW, {4'd0, c.agree_window});
        program_reg(REG_MAX_ATTEMPTS, {8'd0, c.max_attempts});
        program_reg(REG_X_GAIN,       c.x_gain);
        program_reg(REG_X_OFFSET,     c.x_offset);
        program_reg(REG_Y_GAIN,       c.y_gain);
        program_reg(REG_Y_OFFSET,     c.y_offset);
        end_writes();
    endtask

    function automatic t_cfg random_settings();
        t_cfg c;
        c.valid_min    = WIN_BITS'($urandom_range(0, 1500));
        c.valid_max    = WIN_BITS'($urandom_range(2500, 4095));
        c.agree_window = WIN_BITS'($urandom_range(1, 300));
        c.max_attempts = CNT_BITS'($urandom_range(1, 12));
        c.x_gain       = COEF_BITS'($urandom);
        c.x_offset     = COEF_BITS'($urandom);
        c.y_gain       = COEF_BITS'($urandom);
        c.y_offset     = COEF_BITS'($urandom);
        return c;
    endfunction

    function automatic t_cfg make_settings(int vmin, int vmax, int aw, int ma,
                                           int xg, int xo, int yg, int yo);
        t_cfg c;
        c.valid_min    = WIN_BITS'(vmin);
        c.valid_max    = WIN_BITS'(vmax);
        c.agree_window = WIN_BITS'(aw);
        c.max_attempts = CNT_BITS'(ma);
        c.x_gain       = COEF_BITS'(xg);
        c.x_offset     = COEF_BITS'(xo);
        c.y_gain       = COEF_BITS'(yg);
        c.y_offset     = COEF_BITS'(yo);
        return c;
    endfunction

    function automatic int clamp_sample(int v);
        if (v < 0) return 0;
        if (v > 4095) return 4095;
        return v;
    endfunction

    function automatic int pick_base();
        if (sb.cfg.valid_min <= sb.cfg.valid_max)
            return $urandom_range(sb.cfg.valid_min, sb.cfg.valid_max);
        return $urandom_range(0, 4095);
    endfunction

    // Window edges and the values just outside them, plus the converter extremes.
    function automatic logic [SAMPLE_BITS-1:0] edge_value();
        case ($urandom_range(0, 5))
            0:       return sb.cfg.valid_min - 1'b1;
            1:       return sb.cfg.valid_min;
            2:       return sb.cfg.valid_max;
            3:       return sb.cfg.valid_max + 1'b1;
            4:       return '0;
            default: return '1;
        endcase
    endfunction

    // Mostly clusters of pen-down samples around one touch point, jittered around the
    // agreement window so pairs both agree and disagree; the rest is releases, noise and window edges.
    task automatic random_sample(input int pen_pct);
        int r;
        int span;
        logic                   pen;
        logic [SAMPLE_BITS-1:0] x;
        logic [SAMPLE_BITS-1:0] y;
        r   = $urandom_range(0, 99);
        pen = 1'b1;
        if (r < pen_pct) begin
            pen    = 1'b0;
            x      = SAMPLE_BITS'($urandom);
            y      = SAMPLE_BITS'($urandom);
            base_x = pick_base();
            base_y = pick_base();
        end else if (r < pen_pct + 8) begin
            x = SAMPLE_BITS'($urandom);
            y = SAMPLE_BITS'($urandom);
        end else if (r < pen_pct + 14) begin
            x = edge_value();
            y = edge_value();
        end else begin
            if (r < pen_pct + 18) begin
                base_x = pick_base();
                base_y = pick_base();
            end
            span = sb.cfg.agree_window;
            if ($urandom_range(0, 3) == 0) span = 2 * span + 2;
            x = SAMPLE_BITS'(clamp_sample(base_x + $urandom_range(0, span) - span / 2));
            y = SAMPLE_BITS'(clamp_sample(base_y + $urandom_range(0, span) - span / 2));
        end
        send_sample(pen, x, y);
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= '0;
        i_cfg_data      <= '0;
        smp_if.valid    <= 1'b0;
        smp_if.pen_down <= 1'b0;
        smp_if.raw_x    <= '0;
        smp_if.raw_y    <= '0;

        plan[0] = '{make_settings(150, 3900, 40, 5, 'h1000, 100, 'hF000, 'hFF00), 220, 6, 1'b1};
        plan[1] = '{make_settings(0, 4095, 4095, 1, 'h7FFF, 'h7FFF, 'h8000, 'h8000), 220, 5, 1'b0};
        plan[2] = '{make_settings(0, 4095, 0, 7, $urandom, $urandom, $urandom, $urandom),
                    200, 4, 1'b0};
        // inverted window with the largest attempt count: only failures and no releases
        plan[3] = '{make_settings(4095, 0, 50, 255, 'h4000, 0, 'h4000, 0), 600, 0, 1'b0};
        // zero attempt count behaves as one
        plan[4] = '{make_settings(2048, 2048, 1, 0, 'hFFFF, 1, 'h0001, 'hFFFF), 150, 8, 1'b0};
        plan[5] = '{random_settings(), 150, 8, 1'b0};
        plan[6] = '{random_settings(), 150, 8, 1'b0};
        plan[7] = '{make_settings(4095, 4095, 4095, 2, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF),
                    60, 8, 1'b0};

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset settings, gains zero.
        send_sample(1'b0, 12'd4095, 12'd4095);  // release
        send_sample(1'b1, 12'd100, 12'd4000);   // window edges, held
        send_sample(1'b1, 12'd149, 12'd3951);   // just inside agreement
        send_sample(1'b1, 12'd99, 12'd2000);    // below window
        send_sample(1'b1, 12'd2000, 12'd4001);  // above window
        send_sample(1'b1, 12'd2000, 12'd2000);
        send_sample(1'b1, 12'd2050, 12'd2000);  // difference equals window: disagree
        settle();

        // Extreme coefficients, three attempts.
        apply_settings(make_settings(100, 4000, 50, 3, 'h7FFF, 'h8000, 'h8000, 'h7FFF));
        send_sample(1'b1, 12'd4000, 12'd4000);
        send_sample(1'b1, 12'd4000, 12'd4000);
        send_sample(1'b1, 12'd0, 12'd0);
        send_sample(1'b1, 12'd4095, 12'd4095);
        send_sample(1'b1, 12'd0, 12'd4095);     // third failure reports
        send_sample(1'b1, 12'd100, 12'd100);
        send_sample(1'b1, 12'd100, 12'd100);
        send_sample(1'b1, 12'd500, 12'd500);
        send_sample(1'b0, 12'd500, 12'd500);    // release drops the held sample
        send_sample(1'b1, 12'd510, 12'd510);
        send_sample(1'b1, 12'd520, 12'd520);
        send_sample(1'b0, 12'd0, 12'd0);
        settle();

        // Zero attempt count, then an inverted window.
        program_reg(REG_MAX_ATTEMPTS, '0);
        end_writes();
        send_sample(1'b1, 12'd0, 12'd0);
        send_sample(1'b1, 12'd1000, 12'd1000);
        send_sample(1'b1, 12'd1030, 12'd1100);  // y disagrees
        settle();
        program_reg(REG_VALID_MIN, 16'd3000);
        program_reg(REG_VALID_MAX, 16'd1000);
        end_writes();
        send_sample(1'b1, 12'd2000, 12'd2000);
        send_sample(1'b1, 12'd3000, 12'd1000);
        settle();

        foreach (plan[p]) begin
            apply_settings(plan[p].cfg);
            base_x = pick_base();
            base_y = pick_base();
            steady <= plan[p].steady;
            for (int n = 0; n < plan[p].n_items; n++)
                random_sample(plan[p].pen_pct);
            settle();
            steady <= 1'b0;
        end

        repeat (10) @(posedge i_clk);
        if (sb.expected_q.size() != 0) begin
            sb.mismatches++;
            $display("%0d expected results never arrived", sb.expected_q.size());
        end
        $display("Covered %0d samples over %0d coefficient and window settings",
                 sb.n_samples, $size(plan) + 4);
        $display("Results: %0d points, %0d qualification failures, %0d releases, %0d mismatches",
                 sb.n_point, sb.n_fail, sb.n_none, sb.mismatches);
        if (sb.mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/tsq_pkg.sv
rtl/core/tsq_in_if.sv
rtl/core/tsq_out_if.sv
rtl/core/tsq_cfg_regs.sv
rtl/core/tsq_qualify.sv
rtl/core/tsq_scale.sv
rtl/core/touch_sample_qualify_and_scale_unit.sv
tb/tb_touch_sample_qualify_and_scale_unit.sv
